@@ design/pwfe_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and fixed-point helpers for the plane wave field evaluator
// no dependencies

package pwfe_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_ENTRIES  = 24;

	// atan(2^-i) as a fraction of one turn, 32 bit
	localparam logic [31:0] ATAN_TURN [ATAN_ENTRIES] = '{
		32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
		32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
	};

	// Q1.30 values with headroom
	typedef logic signed [33:0] fx_t;

	localparam fx_t         CORDIC_START = 34'sd652032875;
	localparam fx_t         SQRT_HALF    = 34'sd759250125;
	localparam logic [29:0] INV_TWO_PI   = 30'd683565276;

	// hundredths of a degree to turns:
	// floor((m*2^32 + 18000) / 36000) = m*119304 + floor((m*1456 + 1125) / 2250)
	localparam logic [16:0] TURN_WHOLE    = 17'd119304;
	localparam logic [10:0] TURN_REM_MUL  = 11'd1456;
	localparam logic [10:0] TURN_REM_HALF = 11'd1125;
	// ceil(2^39 / 2250), exact quotient for numerators below 2^27
	localparam logic [27:0] TURN_RECIP    = 28'd244335918;
	localparam int          TURN_RECIP_SH = 39;

	// serial units
	localparam int DIV_STEPS  = 64;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
	localparam int SQRT_STEPS = 32;
	localparam int SQRT_CNT_W = $clog2(SQRT_STEPS + 1);

	// time for all setup values to settle after a register write or reset
	localparam int SETTLE_CYCLES = 128 + CORDIC_STAGES;
	localparam int SETTLE_W      = $clog2(SETTLE_CYCLES + 1);

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] REG_THETA = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PHI   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POL   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TILT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_AR    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WAVEN = 3'd5;

	localparam logic [23:0] WAVEN_RESET = 24'd411775;

	// polarization codes
	localparam logic [2:0] POL_V    = 3'd0;
	localparam logic [2:0] POL_H    = 3'd1;
	localparam logic [2:0] POL_RHCP = 3'd2;
	localparam logic [2:0] POL_LHCP = 3'd3;
	localparam logic [2:0] POL_ELL  = 3'd4;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} point_t;

	typedef struct packed {
		logic signed [15:0] e_x_re;
		logic signed [15:0] e_x_im;
		logic signed [15:0] e_y_re;
		logic signed [15:0] e_y_im;
		logic signed [15:0] e_z_re;
		logic signed [15:0] e_z_im;
		logic signed [15:0] h_x_re;
		logic signed [15:0] h_x_im;
		logic signed [15:0] h_y_re;
		logic signed [15:0] h_y_im;
		logic signed [15:0] h_z_re;
		logic signed [15:0] h_z_im;
	} field_t;

	// Q1.30 times Q1.30, rounded half up
	function automatic fx_t mulq(input fx_t a, input fx_t b);
		logic signed [67:0] p;
		p = 68'(a) * 68'(b) + (68'sd1 <<< 29);
		return fx_t'(p >>> 30);
	endfunction

	// Q1.30 to Q2.14 with rounding and saturation
	function automatic logic signed [15:0] sat16(input fx_t v);
		logic signed [34:0] t;
		t = (35'(v) + 35'sd32768) >>> 16;
		if (t > 35'sd32767) begin
			return 16'sh7fff;
		end else if (t < -35'sd32768) begin
			return 16'sh8000;
		end else begin
			return t[15:0];
		end
	endfunction

endpackage

@@ design/pwfe_cordic.sv @@
`timescale 1ns / 1ps
// pipelined rotation cordic: phase in turns to cos and sin in Q1.30
// depends on pwfe_pkg

module pwfe_cordic (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                vld_in,
	input  logic [31:0]         phase,
	output logic                vld_out,
	output pwfe_pkg::fx_t       cos_val,
	output pwfe_pkg::fx_t       sin_val
);

	localparam int N = pwfe_pkg::CORDIC_STAGES;

	logic [N:0]    vld_s;
	pwfe_pkg::fx_t x_s [N+1];
	pwfe_pkg::fx_t y_s [N+1];
	pwfe_pkg::fx_t z_s [N+1];
	logic [1:0]    q_s [N+1];

	logic [31:0]   quad_sum;
	logic [1:0]    quad_in;
	logic [31:0]   resid;
	logic          vld_q;
	pwfe_pkg::fx_t cos_q;
	pwfe_pkg::fx_t sin_q;

	// quadrant and residual within an eighth of a turn
	assign quad_sum = phase + 32'h2000_0000;
	assign quad_in  = quad_sum[31:30];
	assign resid    = phase - {quad_in, 30'd0};

	always_ff @(posedge clk) begin
		x_s[0] <= pwfe_pkg::CORDIC_START;
		y_s[0] <= '0;
		z_s[0] <= pwfe_pkg::fx_t'($signed(resid));
		q_s[0] <= quad_in;
	end

	for (genvar i = 0; i < N; i++) begin : g_rot
		always_ff @(posedge clk) begin
			if (!z_s[i][33]) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - pwfe_pkg::fx_t'({2'b00, pwfe_pkg::ATAN_TURN[i]});
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + pwfe_pkg::fx_t'({2'b00, pwfe_pkg::ATAN_TURN[i]});
			end
			q_s[i+1] <= q_s[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			vld_q <= 1'b0;
		end else begin
			vld_s <= {vld_s[N-1:0], vld_in};
			vld_q <= vld_s[N];
		end
	end

	// fold the quadrant back in
	always_ff @(posedge clk) begin
		case (q_s[N])
			2'd0: begin
				cos_q <= x_s[N];
				sin_q <= y_s[N];
			end
			2'd1: begin
				cos_q <= -y_s[N];
				sin_q <= x_s[N];
			end
			2'd2: begin
				cos_q <= -x_s[N];
				sin_q <= -y_s[N];
			end
			default: begin
				cos_q <= y_s[N];
				sin_q <= -x_s[N];
			end
		endcase
	end

	assign vld_out = vld_q;
	assign cos_val = cos_q;
	assign sin_val = sin_q;

endmodule

@@ design/pwfe_div.sv @@
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle, 64 bit by 32 bit
// depends on pwfe_pkg

module pwfe_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [31:0] den,
	output logic [63:0] quo,
	output logic        done
);

	localparam int W = pwfe_pkg::DIV_CNT_W;

	logic [W-1:0] cnt_q;
	logic         done_q;
	logic [31:0]  rem_q;
	logic [63:0]  quo_q;
	logic [31:0]  den_q;
	logic [32:0]  rem_sh;
	logic [33:0]  diff;

	assign rem_sh = {rem_q, quo_q[63]};
	assign diff   = {1'b0, rem_sh} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == W'(1));
			if (start) begin
				cnt_q <= W'(pwfe_pkg::DIV_STEPS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (cnt_q != '0) begin
			if (!diff[33]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= rem_sh[31:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

endmodule

@@ design/pwfe_isqrt.sv @@
`timescale 1ns / 1ps
// digit-by-digit integer square root, one root bit per cycle, 64 bit radicand
// depends on pwfe_pkg

module pwfe_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] rad,
	output logic [31:0] root,
	output logic        done
);

	localparam int W = pwfe_pkg::SQRT_CNT_W;

	logic [W-1:0] cnt_q;
	logic         done_q;
	logic [63:0]  rad_q;
	logic [33:0]  rem_q;
	logic [31:0]  root_q;
	logic [35:0]  rem_sh;
	logic [35:0]  trial;

	assign rem_sh = {rem_q, rad_q[63:62]};
	assign trial  = {2'b00, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == W'(1));
			if (start) begin
				cnt_q <= W'(pwfe_pkg::SQRT_STEPS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			rad_q <= {rad_q[61:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= 34'(rem_sh - trial);
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[33:0];
				root_q <= {root_q[30:0], 1'b0};
			end
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

@@ design/plane_wave_field_eval_unit.sv @@
`timescale 1ns / 1ps
// top level: incident plane wave E and H at a stream of observation points
// depends on pwfe_pkg, pwfe_cordic, pwfe_div, pwfe_isqrt

// channel   direction  handshake             payload
// ------------------------------------------------------------------------
// point     in         start & !busy         point (pos_x, pos_y, pos_z)
// field     out        strobe, one cycle     field (E and H, re and im)
// config    in         cfg_valid & cfg_ready cfg_index, cfg_data
//
// one point enters per cycle while busy is low; its field beat is on strobe once it has
// passed the phase cordic, which is CORDIC_STAGES + 2 registers deep, and the eight
// product and rounding stages that surround it
// after reset and after every register write busy stays high until the settle counter
// runs out, while unit vectors, polarization vector and ellipse gain rebuild
// the receiver cannot stall, so the pipeline never holds; register writes are always taken

module plane_wave_field_eval_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  pwfe_pkg::point_t                     point,
	output logic                                 strobe,
	output pwfe_pkg::field_t                     field,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [pwfe_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pwfe_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int SW = pwfe_pkg::SETTLE_W;

	// ---------------------------------------------------------------
	// configuration registers
	// ---------------------------------------------------------------
	logic [14:0]        theta_q;
	logic [15:0]        phi_q;
	logic [2:0]         pol_q;
	logic signed [15:0] tilt_q;
	logic signed [16:0] ar_q;
	logic [23:0]        waven_q;
	logic [SW-1:0]      settle_q;
	logic               cfg_wr;
	logic               kick;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			theta_q <= '0;
			phi_q   <= '0;
			pol_q   <= pwfe_pkg::POL_V;
			tilt_q  <= '0;
			ar_q    <= '0;
			waven_q <= pwfe_pkg::WAVEN_RESET;
		end else if (cfg_wr) begin
			case (cfg_index)
				pwfe_pkg::REG_THETA: theta_q <= cfg_data[14:0];
				pwfe_pkg::REG_PHI:   phi_q   <= cfg_data[15:0];
				pwfe_pkg::REG_POL:   pol_q   <= cfg_data[2:0];
				pwfe_pkg::REG_TILT:  tilt_q  <= cfg_data[15:0];
				pwfe_pkg::REG_AR:    ar_q    <= cfg_data[16:0];
				pwfe_pkg::REG_WAVEN: waven_q <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// settle counter: busy until every setup value has been rebuilt
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SW'(pwfe_pkg::SETTLE_CYCLES);
		end else if (cfg_wr) begin
			settle_q <= SW'(pwfe_pkg::SETTLE_CYCLES);
		end else if (settle_q != '0) begin
			settle_q <= settle_q - SW'(1);
		end
	end

	// first cycle of a settle window restarts the serial units
	assign kick = (settle_q == SW'(pwfe_pkg::SETTLE_CYCLES));
	assign busy = (settle_q != '0);

	// ---------------------------------------------------------------
	// setup path: angles to turns, round half up on the magnitude
	// ---------------------------------------------------------------
	logic [15:0] tilt_mag;
	logic [15:0] ang_mag  [3];
	logic [31:0] whole_q  [3];
	logic [26:0] frac_q   [3];
	logic [54:0] frac_prod [3];
	logic [31:0] turn_q   [3];
	logic [31:0] turn_th, turn_ph, turn_tl;

	assign tilt_mag   = tilt_q[15] ? 16'(-tilt_q) : 16'(tilt_q);
	assign ang_mag[0] = {1'b0, theta_q};
	assign ang_mag[1] = phi_q;
	assign ang_mag[2] = tilt_mag;

	// whole turns part plus the rounded remainder, divided by reciprocal multiply
	for (genvar k = 0; k < 3; k++) begin : g_turn
		assign frac_prod[k] = 55'(frac_q[k]) * 55'(pwfe_pkg::TURN_RECIP);

		always_ff @(posedge clk) begin
			whole_q[k] <= 32'(ang_mag[k]) * 32'(pwfe_pkg::TURN_WHOLE);
			frac_q[k]  <= 27'(ang_mag[k]) * 27'(pwfe_pkg::TURN_REM_MUL)
				+ 27'(pwfe_pkg::TURN_REM_HALF);
			turn_q[k]  <= whole_q[k] + 32'(frac_prod[k] >> pwfe_pkg::TURN_RECIP_SH);
		end
	end

	assign turn_th = turn_q[0];
	assign turn_ph = turn_q[1];
	assign turn_tl = tilt_q[15] ? (32'd0 - turn_q[2]) : turn_q[2];

	pwfe_pkg::fx_t ct, st, cp, sp, ca, sa;

	pwfe_cordic u_cordic_th (
		.clk(clk), .arst_n(arst_n), .vld_in(1'b1), .phase(turn_th),
		.vld_out(), .cos_val(ct), .sin_val(st)
	);
	pwfe_cordic u_cordic_ph (
		.clk(clk), .arst_n(arst_n), .vld_in(1'b1), .phase(turn_ph),
		.vld_out(), .cos_val(cp), .sin_val(sp)
	);
	pwfe_cordic u_cordic_tl (
		.clk(clk), .arst_n(arst_n), .vld_in(1'b1), .phase(turn_tl),
		.vld_out(), .cos_val(ca), .sin_val(sa)
	);

	// ellipse gain: q = isqrt((2^24 + ar^2) << 28), g = round(2^56 / q)
	logic signed [33:0] ar_sq;
	logic [33:0]        ar_sum;
	logic [63:0]        sq_rad;
	logic [31:0]        sq_root;
	logic               sq_done;
	logic [63:0]        num_g;
	logic [63:0]        quo_g;
	logic               g_done;
	pwfe_pkg::fx_t      g_q;
	pwfe_pkg::fx_t      gr_q;
	logic signed [50:0] gr_prod;

	assign ar_sq  = 34'(ar_q) * 34'(ar_q);
	assign ar_sum = 34'(ar_sq) + 34'd16777216;
	assign sq_rad = {2'b00, ar_sum, 28'd0};

	pwfe_isqrt u_isqrt (
		.clk(clk), .arst_n(arst_n), .start(kick), .rad(sq_rad),
		.root(sq_root), .done(sq_done)
	);

	assign num_g = {7'd0, 1'b1, 56'd0} + {33'd0, sq_root[31:1]};

	pwfe_div u_div_g (
		.clk(clk), .arst_n(arst_n), .start(sq_done), .num(num_g),
		.den(sq_root), .quo(quo_g), .done(g_done)
	);

	assign gr_prod = 51'(g_q) * 51'(ar_q);

	always_ff @(posedge clk) begin
		if (g_done) begin
			g_q <= pwfe_pkg::fx_t'({2'b00, quo_g[31:0]});
		end
		gr_q <= pwfe_pkg::fx_t'((gr_prod + 51'sd2048) >>> 12);
	end

	// unit vectors r, theta-hat, phi-hat and the polarization vector;
	// these registers run freely and hold still once config is quiet
	pwfe_pkg::fx_t r_q     [3];
	pwfe_pkg::fx_t t_q     [3];
	pwfe_pkg::fx_t p_q     [3];
	pwfe_pkg::fx_t tca_q   [3];
	pwfe_pkg::fx_t psa_q   [3];
	pwfe_pkg::fx_t pca_q   [3];
	pwfe_pkg::fx_t tsa_q   [3];
	pwfe_pkg::fx_t sqt_q   [3];
	pwfe_pkg::fx_t sqp_q   [3];
	pwfe_pkg::fx_t major_q [3];
	pwfe_pkg::fx_t minor_q [3];
	pwfe_pkg::fx_t ga_q    [3];
	pwfe_pkg::fx_t gb_q    [3];
	pwfe_pkg::fx_t a_q     [3];
	pwfe_pkg::fx_t b_q     [3];
	logic [53:0]   kt_q;

	always_ff @(posedge clk) begin
		r_q[0] <= pwfe_pkg::mulq(st, cp);
		r_q[1] <= pwfe_pkg::mulq(st, sp);
		r_q[2] <= ct;
		t_q[0] <= pwfe_pkg::mulq(ct, cp);
		t_q[1] <= pwfe_pkg::mulq(ct, sp);
		t_q[2] <= -st;
		p_q[0] <= -sp;
		p_q[1] <= cp;
		p_q[2] <= '0;
		// turns per length unit
		kt_q   <= 54'(waven_q) * 54'(pwfe_pkg::INV_TWO_PI);
	end

	for (genvar k = 0; k < 3; k++) begin : g_pol
		always_ff @(posedge clk) begin
			tca_q[k]   <= pwfe_pkg::mulq(t_q[k], ca);
			psa_q[k]   <= pwfe_pkg::mulq(p_q[k], sa);
			pca_q[k]   <= pwfe_pkg::mulq(p_q[k], ca);
			tsa_q[k]   <= pwfe_pkg::mulq(t_q[k], sa);
			sqt_q[k]   <= pwfe_pkg::mulq(pwfe_pkg::SQRT_HALF, t_q[k]);
			sqp_q[k]   <= pwfe_pkg::mulq(pwfe_pkg::SQRT_HALF, p_q[k]);
			major_q[k] <= tca_q[k] + psa_q[k];
			minor_q[k] <= pca_q[k] - tsa_q[k];
			ga_q[k]    <= pwfe_pkg::mulq(g_q, major_q[k]);
			gb_q[k]    <= pwfe_pkg::mulq(gr_q, minor_q[k]);
			case (pol_q)
				pwfe_pkg::POL_V: begin
					a_q[k] <= -t_q[k];
					b_q[k] <= '0;
				end
				pwfe_pkg::POL_H: begin
					a_q[k] <= p_q[k];
					b_q[k] <= '0;
				end
				pwfe_pkg::POL_RHCP: begin
					a_q[k] <= sqt_q[k];
					b_q[k] <= sqp_q[k];
				end
				pwfe_pkg::POL_LHCP: begin
					a_q[k] <= sqt_q[k];
					b_q[k] <= -sqp_q[k];
				end
				pwfe_pkg::POL_ELL: begin
					a_q[k] <= ga_q[k];
					b_q[k] <= gb_q[k];
				end
				default: begin
					// unused codes give an all-zero field
					a_q[k] <= '0;
					b_q[k] <= '0;
				end
			endcase
		end
	end

	// ---------------------------------------------------------------
	// point pipeline
	// ---------------------------------------------------------------
	logic acc;
	assign acc = start & ~busy;

	// s1: projections of the point on r
	logic signed [65:0] prx_s1, pry_s1, prz_s1;
	// s2: rounded distance along r, Q16.16
	logic signed [65:0] dsum;
	logic signed [35:0] d_s2;
	// s3: partial products of d * kt, modulo 2^64
	logic [63:0]        d64;
	logic [63:0]        m0;
	logic [31:0]        m1, m2;
	logic [31:0]        m0_s3, m1_s3, m2_s3;
	// s4: phase in turns
	logic [31:0]        phase_s4;
	logic               vld_s1, vld_s2, vld_s3, vld_s4;

	always_ff @(posedge clk) begin
		prx_s1 <= 66'(point.pos_x) * 66'(r_q[0]);
		pry_s1 <= 66'(point.pos_y) * 66'(r_q[1]);
		prz_s1 <= 66'(point.pos_z) * 66'(r_q[2]);
	end

	assign dsum = prx_s1 + pry_s1 + prz_s1 + (66'sd1 <<< 29);

	always_ff @(posedge clk) begin
		d_s2 <= 36'(dsum >>> 30);
	end

	// bits 63..32 of d*kt: hi(dlo*ktlo) + lo(dhi*ktlo) + lo(dlo*kthi)
	assign d64 = 64'(d_s2);
	assign m0  = {32'd0, d64[31:0]} * {32'd0, kt_q[31:0]};
	assign m1  = d64[63:32] * kt_q[31:0];
	assign m2  = d64[31:0] * {10'd0, kt_q[53:32]};

	always_ff @(posedge clk) begin
		m0_s3    <= m0[63:32];
		m1_s3    <= m1;
		m2_s3    <= m2;
		phase_s4 <= m0_s3 + m1_s3 + m2_s3;
	end

	// cos + j sin of the phase
	pwfe_pkg::fx_t pc, ps;
	logic          vld_c;

	pwfe_cordic u_cordic_pt (
		.clk(clk), .arst_n(arst_n), .vld_in(vld_s4), .phase(phase_s4),
		.vld_out(vld_c), .cos_val(pc), .sin_val(ps)
	);

	// s5: polarization times the phasor, s6: E, s7: H products
	pwfe_pkg::fx_t      apc_s5 [3];
	pwfe_pkg::fx_t      bps_s5 [3];
	pwfe_pkg::fx_t      aps_s5 [3];
	pwfe_pkg::fx_t      bpc_s5 [3];
	pwfe_pkg::fx_t      er_s6  [3];
	pwfe_pkg::fx_t      ei_s6  [3];
	pwfe_pkg::fx_t      hra_s7 [3];
	pwfe_pkg::fx_t      hrb_s7 [3];
	pwfe_pkg::fx_t      hia_s7 [3];
	pwfe_pkg::fx_t      hib_s7 [3];
	logic signed [15:0] ero_s7 [3];
	logic signed [15:0] eio_s7 [3];
	logic signed [15:0] hro    [3];
	logic signed [15:0] hio    [3];
	logic               vld_s5, vld_s6, vld_s7;
	logic               strobe_q;
	pwfe_pkg::field_t   res_q;

	for (genvar k = 0; k < 3; k++) begin : g_field
		localparam int I1 = (k + 1) % 3;
		localparam int I2 = (k + 2) % 3;

		always_ff @(posedge clk) begin
			apc_s5[k] <= pwfe_pkg::mulq(a_q[k], pc);
			bps_s5[k] <= pwfe_pkg::mulq(b_q[k], ps);
			aps_s5[k] <= pwfe_pkg::mulq(a_q[k], ps);
			bpc_s5[k] <= pwfe_pkg::mulq(b_q[k], pc);
			er_s6[k]  <= apc_s5[k] - bps_s5[k];
			ei_s6[k]  <= aps_s5[k] + bpc_s5[k];
			// H = -r x E
			hra_s7[k] <= pwfe_pkg::mulq(r_q[I2], er_s6[I1]);
			hrb_s7[k] <= pwfe_pkg::mulq(r_q[I1], er_s6[I2]);
			hia_s7[k] <= pwfe_pkg::mulq(r_q[I2], ei_s6[I1]);
			hib_s7[k] <= pwfe_pkg::mulq(r_q[I1], ei_s6[I2]);
			ero_s7[k] <= pwfe_pkg::sat16(er_s6[k]);
			eio_s7[k] <= pwfe_pkg::sat16(ei_s6[k]);
		end

		assign hro[k] = pwfe_pkg::sat16(hra_s7[k] - hrb_s7[k]);
		assign hio[k] = pwfe_pkg::sat16(hia_s7[k] - hib_s7[k]);
	end

	// output register
	always_ff @(posedge clk) begin
		res_q.e_x_re <= ero_s7[0];
		res_q.e_x_im <= eio_s7[0];
		res_q.e_y_re <= ero_s7[1];
		res_q.e_y_im <= eio_s7[1];
		res_q.e_z_re <= ero_s7[2];
		res_q.e_z_im <= eio_s7[2];
		res_q.h_x_re <= hro[0];
		res_q.h_x_im <= hio[0];
		res_q.h_y_re <= hro[1];
		res_q.h_y_im <= hio[1];
		res_q.h_z_re <= hro[2];
		res_q.h_z_im <= hio[2];
	end

	// valid bits travel with the beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			vld_s3   <= 1'b0;
			vld_s4   <= 1'b0;
			vld_s5   <= 1'b0;
			vld_s6   <= 1'b0;
			vld_s7   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			vld_s1   <= acc;
			vld_s2   <= vld_s1;
			vld_s3   <= vld_s2;
			vld_s4   <= vld_s3;
			vld_s5   <= vld_c;
			vld_s6   <= vld_s5;
			vld_s7   <= vld_s6;
			strobe_q <= vld_s7;
		end
	end

	assign strobe = strobe_q;
	assign field  = res_q;

endmodule
